@@ hw/rtl/rmq_pkg.sv @@
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared types and constants for the rotation matrix to quaternion block.
// ----------------------------------------------------------------------------
package rmq_pkg;

  // element and component widths
  localparam int IN_W  = 16;
  localparam int MAG_W = 17;
  localparam int OUT_W = 16;

  // which component leads
  typedef enum logic [1:0] {
    BR_W = 2'd0,
    BR_X = 2'd1,
    BR_Y = 2'd2,
    BR_Z = 2'd3
  } branch_t;

  // classified numerators, in w/x/y/z order with the leading slot skipped
  typedef struct packed {
    logic [2:0]            neg;
    logic [2:0][MAG_W-1:0] mag;
    branch_t               br;
    logic                  clamped;
  } rmq_num_t;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } rmq_fifo_stat_t;

endpackage

@@ hw/rtl/rmq_if.sv @@
// ----------------------------------------------------------------------------
// rmq_in_if / rmq_out_if
// Valid/ready channels for matrix words and quaternion words.
// ----------------------------------------------------------------------------
interface rmq_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] m00;
  logic signed [15:0] m01;
  logic signed [15:0] m02;
  logic signed [15:0] m10;
  logic signed [15:0] m11;
  logic signed [15:0] m12;
  logic signed [15:0] m20;
  logic signed [15:0] m21;
  logic signed [15:0] m22;

  modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  input ready);
  modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  output ready);
endinterface

interface rmq_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] qw;
  logic signed [15:0] qx;
  logic signed [15:0] qy;
  logic signed [15:0] qz;
  logic [1:0]         branch_taken;
  logic               clamped;

  modport source (output valid, qw, qx, qy, qz, branch_taken, clamped,
                  input ready);
  modport sink   (input valid, qw, qx, qy, qz, branch_taken, clamped,
                  output ready);
endinterface

@@ hw/rtl/rmq_front.sv @@
// ----------------------------------------------------------------------------
// rmq_front
// Accepts a matrix word, picks the branch, forms the square-root argument
// and the three signed numerators.
// ----------------------------------------------------------------------------
module rmq_front #(
  parameter int FRAC_BITS = 14,
  parameter int ARG_W     = 19
) (
  rmq_in_if.sink                 mat,
  input  rmq_pkg::rmq_fifo_stat_t stat,
  output logic                   push,
  output rmq_pkg::rmq_num_t      num,
  output logic [ARG_W-1:0]       arg
);

  localparam int SW = ARG_W + 1;
  localparam logic signed [SW-1:0] ONE_S = SW'(1) << FRAC_BITS;

  logic signed [SW-1:0] e00, e11, e22, tr, a_raw;
  logic signed [rmq_pkg::MAG_W-1:0] dx, dy, dz, s01, s02, s12;
  logic signed [rmq_pkg::MAG_W-1:0] n [3];
  rmq_pkg::branch_t br;

  // handshake: take a word whenever the queue has room
  assign mat.ready = !stat.full;
  assign push      = mat.valid && !stat.full;

  // trace and branch choice
  assign e00 = SW'($signed(mat.m00));
  assign e11 = SW'($signed(mat.m11));
  assign e22 = SW'($signed(mat.m22));
  assign tr  = e00 + e11 + e22;

  always_comb begin
    if (tr > 0) begin
      br    = rmq_pkg::BR_W;
      a_raw = tr + ONE_S;
    end else if (e00 > e11 && e00 > e22) begin
      br    = rmq_pkg::BR_X;
      a_raw = ONE_S + e00 - e11 - e22;
    end else if (e11 > e22) begin
      br    = rmq_pkg::BR_Y;
      a_raw = ONE_S + e11 - e00 - e22;
    end else begin
      br    = rmq_pkg::BR_Z;
      a_raw = ONE_S + e22 - e00 - e11;
    end
  end

  // clamp a non-positive argument to one lsb
  assign arg         = (a_raw <= 0) ? ARG_W'(1) : a_raw[ARG_W-1:0];
  assign num.clamped = (a_raw <= 0);
  assign num.br      = br;

  // off-diagonal sums and differences
  assign dx  = rmq_pkg::MAG_W'($signed(mat.m21)) - rmq_pkg::MAG_W'($signed(mat.m12));
  assign dy  = rmq_pkg::MAG_W'($signed(mat.m02)) - rmq_pkg::MAG_W'($signed(mat.m20));
  assign dz  = rmq_pkg::MAG_W'($signed(mat.m10)) - rmq_pkg::MAG_W'($signed(mat.m01));
  assign s01 = rmq_pkg::MAG_W'($signed(mat.m01)) + rmq_pkg::MAG_W'($signed(mat.m10));
  assign s02 = rmq_pkg::MAG_W'($signed(mat.m02)) + rmq_pkg::MAG_W'($signed(mat.m20));
  assign s12 = rmq_pkg::MAG_W'($signed(mat.m12)) + rmq_pkg::MAG_W'($signed(mat.m21));

  // numerators for the non-leading slots, in component order
  always_comb begin
    case (br)
      rmq_pkg::BR_W: begin
        n[0] = dx;  n[1] = dy;  n[2] = dz;
      end
      rmq_pkg::BR_X: begin
        n[0] = dx;  n[1] = s01; n[2] = s02;
      end
      rmq_pkg::BR_Y: begin
        n[0] = dy;  n[1] = s01; n[2] = s12;
      end
      default: begin
        n[0] = dz;  n[1] = s02; n[2] = s12;
      end
    endcase
  end

  // split into sign and magnitude
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num.neg[i] = n[i][rmq_pkg::MAG_W-1];
      num.mag[i] = n[i][rmq_pkg::MAG_W-1] ? rmq_pkg::MAG_W'(-n[i])
                                           : rmq_pkg::MAG_W'(n[i]);
    end
  end

endmodule

@@ hw/rtl/rmq_fifo.sv @@
// ----------------------------------------------------------------------------
// rmq_fifo
// Small queue between the classify front and the arithmetic back.
// ----------------------------------------------------------------------------
module rmq_fifo #(
  parameter int W     = 64,
  parameter int DEPTH = 4
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  logic                    pop,
  input  logic [W-1:0]            din,
  output logic [W-1:0]            dout,
  output rmq_pkg::rmq_fifo_stat_t stat
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] cnt;

  assign stat.full  = (cnt == CW'(DEPTH));
  assign stat.empty = (cnt == '0);
  assign dout       = mem[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) wr_ptr <= PW'((wr_ptr + 1'b1) % DEPTH);
      if (pop)  rd_ptr <= PW'((rd_ptr + 1'b1) % DEPTH);
      cnt <= cnt + CW'(push) - CW'(pop);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= din;
  end

endmodule

@@ hw/rtl/rmq_sqrt.sv @@
// ----------------------------------------------------------------------------
// rmq_sqrt
// Pipelined integer square root of arg * 2^(FRAC_BITS+2), two radicand
// bits per stage.
// ----------------------------------------------------------------------------
module rmq_sqrt #(
  parameter int FRAC_BITS = 14,
  parameter int ARG_W     = 19
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [ARG_W-1:0]     arg,
  output logic [(ARG_W+FRAC_BITS+3)/2-1:0] root
);

  localparam int RAD_RAW = ARG_W + FRAC_BITS + 2;
  localparam int RAD_W   = RAD_RAW + RAD_RAW % 2;
  localparam int N       = RAD_W / 2;
  localparam int REM_W   = N + 1;

  logic [ARG_W-1:0] a_q  [N+1];
  logic [N-1:0]     rt_q [N+1];
  logic [REM_W-1:0] rm_q [N+1];

  assign a_q[0]  = arg;
  assign rt_q[0] = '0;
  assign rm_q[0] = '0;
  assign root    = rt_q[N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [RAD_W-1:0] radv;
    logic [1:0]       bb;
    logic [N+2:0]     cand, trial;
    logic             take;

    // next radicand digit pair, trial subtract
    assign radv  = RAD_W'({a_q[k], {(FRAC_BITS + 2){1'b0}}});
    assign bb    = radv[RAD_W-1-2*k -: 2];
    assign cand  = {rm_q[k], bb};
    assign trial = (N + 3)'({rt_q[k], 2'b01});
    assign take  = (cand >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        a_q[k+1]  <= a_q[k];
        rm_q[k+1] <= take ? REM_W'(cand - trial) : REM_W'(cand);
        rt_q[k+1] <= {rt_q[k][N-2:0], take};
      end
    end
  end

endmodule

@@ hw/rtl/rmq_div.sv @@
// ----------------------------------------------------------------------------
// rmq_div
// Pipelined restoring divider: (mag << FRAC_BITS + s/2) / s, one quotient
// bit per stage.
// ----------------------------------------------------------------------------
module rmq_div #(
  parameter int FRAC_BITS = 14,
  parameter int SW        = 18
) (
  input  logic                                   clk,
  input  logic                                   en,
  input  logic [rmq_pkg::MAG_W-1:0]              mag,
  input  logic [SW-1:0]                          s,
  output logic [rmq_pkg::MAG_W+FRAC_BITS:0]      q
);

  localparam int DW = rmq_pkg::MAG_W + FRAC_BITS + 1;

  logic [DW-1:0] d_q [DW+1];
  logic [DW-1:0] q_q [DW+1];
  logic [SW-1:0] s_q [DW+1];
  logic [SW-1:0] r_q [DW+1];

  // dividend with the rounding half added
  assign d_q[0] = DW'({mag, {FRAC_BITS{1'b0}}}) + DW'(s >> 1);
  assign s_q[0] = s;
  assign q_q[0] = '0;
  assign r_q[0] = '0;
  assign q      = q_q[DW];

  for (genvar k = 0; k < DW; k++) begin : g_stage
    logic [SW:0] rr;
    logic        take;

    // shift in the next dividend bit and try the subtract
    assign rr   = {r_q[k], d_q[k][DW-1-k]};
    assign take = (rr >= {1'b0, s_q[k]});

    always_ff @(posedge clk) begin
      if (en) begin
        d_q[k+1] <= d_q[k];
        s_q[k+1] <= s_q[k];
        r_q[k+1] <= take ? SW'(rr - {1'b0, s_q[k]}) : SW'(rr);
        q_q[k+1] <= {q_q[k][DW-2:0], take};
      end
    end
  end

endmodule

@@ hw/rtl/rmq_back.sv @@
// ----------------------------------------------------------------------------
// rmq_back
// Square root, three dividers and output assembly; stalls as a whole when
// the output word is not taken.
// ----------------------------------------------------------------------------
module rmq_back #(
  parameter int FRAC_BITS = 14,
  parameter int ARG_W     = 19
) (
  input  logic                    clk,
  input  logic                    rst,
  input  rmq_pkg::rmq_fifo_stat_t stat,
  output logic                    pop,
  input  rmq_pkg::rmq_num_t       num,
  input  logic [ARG_W-1:0]        arg,
  rmq_out_if.source               quat
);

  localparam int RAD_RAW = ARG_W + FRAC_BITS + 2;
  localparam int N       = (RAD_RAW + RAD_RAW % 2) / 2;
  localparam int DW      = rmq_pkg::MAG_W + FRAC_BITS + 1;
  localparam longint POS_LIM = (FRAC_BITS >= 15) ? 32767 : (64'sd1 <<< FRAC_BITS);
  localparam longint NEG_LIM = (FRAC_BITS >= 15) ? 32768 : (64'sd1 <<< FRAC_BITS);

  typedef struct packed {
    logic [2:0]       neg;
    rmq_pkg::branch_t br;
    logic             clamped;
    logic [N-1:0]     lead;
  } side_b_t;

  logic                en;
  logic                vld_a  [N+1];
  rmq_pkg::rmq_num_t   side_a [N+1];
  logic                vld_b  [DW+1];
  side_b_t             side_b [DW+1];
  logic [N-1:0]        s;
  logic [DW-1:0]       qd [3];
  logic [DW-1:0]       c_mag [4];
  logic [3:0]          c_neg;

  function automatic logic [rmq_pkg::OUT_W-1:0] sat(input logic neg, input logic [DW-1:0] m);
    logic [DW-1:0] lim;
    logic [DW-1:0] v;
    lim = neg ? DW'(NEG_LIM) : DW'(POS_LIM);
    v   = (m > lim) ? lim : m;
    return neg ? rmq_pkg::OUT_W'(-v) : rmq_pkg::OUT_W'(v);
  endfunction

  // whole pipeline moves unless the output word is stuck
  assign en  = !quat.valid || quat.ready;
  assign pop = en && !stat.empty;

  // square-root section
  assign vld_a[0]  = pop;
  assign side_a[0] = num;

  rmq_sqrt #(.FRAC_BITS(FRAC_BITS), .ARG_W(ARG_W)) u_sqrt (
    .clk  (clk),
    .en   (en),
    .arg  (arg),
    .root (s)
  );

  for (genvar k = 0; k < N; k++) begin : g_side_a
    always_ff @(posedge clk) begin
      if (rst) begin
        vld_a[k+1] <= 1'b0;
      end else if (en) begin
        vld_a[k+1] <= vld_a[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) side_a[k+1] <= side_a[k];
    end
  end

  // divider section
  assign vld_b[0]          = vld_a[N];
  assign side_b[0].neg     = side_a[N].neg;
  assign side_b[0].br      = side_a[N].br;
  assign side_b[0].clamped = side_a[N].clamped;
  assign side_b[0].lead    = N'((s + N'(2)) >> 2);

  for (genvar i = 0; i < 3; i++) begin : g_div
    rmq_div #(.FRAC_BITS(FRAC_BITS), .SW(N)) u_div (
      .clk (clk),
      .en  (en),
      .mag (side_a[N].mag[i]),
      .s   (s),
      .q   (qd[i])
    );
  end

  for (genvar k = 0; k < DW; k++) begin : g_side_b
    always_ff @(posedge clk) begin
      if (rst) begin
        vld_b[k+1] <= 1'b0;
      end else if (en) begin
        vld_b[k+1] <= vld_b[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) side_b[k+1] <= side_b[k];
    end
  end

  // place the leading component and the three quotients
  always_comb begin
    c_mag[0] = qd[0]; c_mag[1] = qd[1]; c_mag[2] = qd[2]; c_mag[3] = qd[2];
    c_neg    = 4'b0000;
    case (side_b[DW].br)
      rmq_pkg::BR_W: begin
        c_mag[0] = DW'(side_b[DW].lead); c_mag[1] = qd[0];
        c_mag[2] = qd[1];                c_mag[3] = qd[2];
        c_neg    = {side_b[DW].neg[2], side_b[DW].neg[1], side_b[DW].neg[0], 1'b0};
      end
      rmq_pkg::BR_X: begin
        c_mag[0] = qd[0];                c_mag[1] = DW'(side_b[DW].lead);
        c_mag[2] = qd[1];                c_mag[3] = qd[2];
        c_neg    = {side_b[DW].neg[2], side_b[DW].neg[1], 1'b0, side_b[DW].neg[0]};
      end
      rmq_pkg::BR_Y: begin
        c_mag[0] = qd[0];                c_mag[1] = qd[1];
        c_mag[2] = DW'(side_b[DW].lead); c_mag[3] = qd[2];
        c_neg    = {side_b[DW].neg[2], 1'b0, side_b[DW].neg[1], side_b[DW].neg[0]};
      end
      default: begin
        c_mag[0] = qd[0];                c_mag[1] = qd[1];
        c_mag[2] = qd[2];                c_mag[3] = DW'(side_b[DW].lead);
        c_neg    = {1'b0, side_b[DW].neg[2], side_b[DW].neg[1], side_b[DW].neg[0]};
      end
    endcase
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      quat.valid <= 1'b0;
    end else if (en) begin
      quat.valid <= vld_b[DW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quat.qw           <= sat(c_neg[0], c_mag[0]);
      quat.qx           <= sat(c_neg[1], c_mag[1]);
      quat.qy           <= sat(c_neg[2], c_mag[2]);
      quat.qz           <= sat(c_neg[3], c_mag[3]);
      quat.branch_taken <= side_b[DW].br;
      quat.clamped      <= side_b[DW].clamped;
    end
  end

endmodule

@@ hw/rtl/rotation_matrix_to_quaternion.sv @@
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Rotation matrix to unit quaternion by the four-branch trace method.
// ----------------------------------------------------------------------------
// pipeline: N = ceil((ARG_W+FRAC_BITS+2)/2) root stages, the divider
//   stages and one output register; 18 root and 32 divider stages at
//   FRAC_BITS = 14
// throughput: one word per cycle, set by the one-step-per-stage root and
//   divider pipelines; the whole back end stalls while the output is held
// reset: clears the queue pointers and all pipeline valid bits
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion #(
  parameter int FRAC_BITS = 14
) (
  input logic       clk,
  input logic       rst,
  rmq_in_if.sink    mat,
  rmq_out_if.source quat
);

  localparam int ARG_W = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2;
  localparam int QW    = ARG_W + $bits(rmq_pkg::rmq_num_t);

  rmq_pkg::rmq_fifo_stat_t stat;
  rmq_pkg::rmq_num_t       num_in, num_out;
  logic [ARG_W-1:0]        arg_in, arg_out;
  logic                    push, pop;

  // classify
  rmq_front #(.FRAC_BITS(FRAC_BITS), .ARG_W(ARG_W)) u_front (
    .mat  (mat),
    .stat (stat),
    .push (push),
    .num  (num_in),
    .arg  (arg_in)
  );

  // decoupling queue
  rmq_fifo #(.W(QW), .DEPTH(4)) u_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .din  ({arg_in, num_in}),
    .dout ({arg_out, num_out}),
    .stat (stat)
  );

  // arithmetic
  rmq_back #(.FRAC_BITS(FRAC_BITS), .ARG_W(ARG_W)) u_back (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .pop  (pop),
    .num  (num_out),
    .arg  (arg_out),
    .quat (quat)
  );

  // input is refused only when the queue is full
  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !mat.ready |-> stat.full)
    else $error("input refused with queue room");

  // a positive trace never needs the clamp
  a_trace_clamp: assert property (@(posedge clk) disable iff (rst)
    quat.valid && quat.branch_taken == rmq_pkg::BR_W |-> !quat.clamped)
    else $error("clamp flagged on positive trace");

  // the leading w component is never negative
  a_lead_sign: assert property (@(posedge clk) disable iff (rst)
    quat.valid && quat.branch_taken == rmq_pkg::BR_W |-> !quat.qw[15])
    else $error("negative leading component");

  // nothing is popped from an empty queue
  a_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !stat.empty)
    else $error("pop from empty queue");

endmodule

@@ test/rotation_matrix_to_quaternion_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_tb
// Drives matrix words with random gaps, predicts each quaternion word with a
// behavioral model of the trace method, and checks every output word in order.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_tb;

  localparam int FRAC = 14;
  localparam longint ONE = 64'sd1 << FRAC;
  localparam int LATENCY = 52;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int N_RANDOM = 1700;

  typedef struct {
    logic signed [15:0] m [9];
  } matrix_t;

  typedef struct {
    logic signed [15:0] qw, qx, qy, qz;
    rmq_pkg::branch_t   br;
    logic               clamped;
  } quat_t;

  // expected quaternion store and checker
  class quat_scoreboard;
    quat_t pending[$];
    int    mismatches;

    static function longint root_floor(longint v);
      longint r, b;
      r = 0;
      b = 64'sd1 << 60;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    static function longint ratio_round(longint n, longint s);
      longint mag, q;
      mag = (n < 0) ? -n : n;
      q = ((mag << FRAC) + (s >> 1)) / s;
      return (n < 0) ? -q : q;
    endfunction

    static function logic signed [15:0] limit_one(longint v);
      if (v > ONE) v = ONE;
      if (v < -ONE) v = -ONE;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[15:0];
    endfunction

    function void note_matrix(matrix_t a);
      longint m[9];
      longint tr, arg, s, lead, w, x, y, z;
      quat_t e;
      foreach (m[i]) m[i] = a.m[i];
      tr = m[0] + m[4] + m[8];
      e.clamped = 1'b0;
      if (tr > 0) begin
        e.br = rmq_pkg::BR_W; arg = tr + ONE;
      end else if (m[0] > m[4] && m[0] > m[8]) begin
        e.br = rmq_pkg::BR_X; arg = ONE + m[0] - m[4] - m[8];
      end else if (m[4] > m[8]) begin
        e.br = rmq_pkg::BR_Y; arg = ONE + m[4] - m[0] - m[8];
      end else begin
        e.br = rmq_pkg::BR_Z; arg = ONE + m[8] - m[0] - m[4];
      end
      if (arg <= 0) begin
        arg = 1; e.clamped = 1'b1;
      end
      s = root_floor(arg << (FRAC + 2));
      lead = (s + 2) >> 2;
      case (e.br)
        rmq_pkg::BR_W: begin
          w = lead;
          x = ratio_round(m[7] - m[5], s);
          y = ratio_round(m[2] - m[6], s);
          z = ratio_round(m[3] - m[1], s);
        end
        rmq_pkg::BR_X: begin
          w = ratio_round(m[7] - m[5], s);
          x = lead;
          y = ratio_round(m[1] + m[3], s);
          z = ratio_round(m[2] + m[6], s);
        end
        rmq_pkg::BR_Y: begin
          w = ratio_round(m[2] - m[6], s);
          x = ratio_round(m[1] + m[3], s);
          y = lead;
          z = ratio_round(m[5] + m[7], s);
        end
        default: begin
          w = ratio_round(m[3] - m[1], s);
          x = ratio_round(m[2] + m[6], s);
          y = ratio_round(m[5] + m[7], s);
          z = lead;
        end
      endcase
      e.qw = limit_one(w);
      e.qx = limit_one(x);
      e.qy = limit_one(y);
      e.qz = limit_one(z);
      pending = {pending, e};
    endfunction

    function void check_quat(quat_t got);
      quat_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected quaternion word");
        return;
      end
      e = pending.pop_front();
      if (got.qw !== e.qw || got.qx !== e.qx || got.qy !== e.qy ||
          got.qz !== e.qz || got.br !== e.br || got.clamped !== e.clamped) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp %0d %0d %0d %0d br%0d c%0b got %0d %0d %0d %0d br%0d c%0b",
                   e.qw, e.qx, e.qy, e.qz, e.br, e.clamped,
                   got.qw, got.qx, got.qy, got.qz, got.br, got.clamped);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   idle_pct = 10;
  int   watchdog = 0;

  rmq_in_if  mat ();
  rmq_out_if quat ();

  rotation_matrix_to_quaternion #(.FRAC_BITS(FRAC)) dut (
    .clk (clk),
    .rst (rst),
    .mat (mat.sink),
    .quat(quat.source)
  );

  quat_scoreboard sb = new();

  always #2 clk = ~clk;

  // output side: random stalls, check at rising edge
  always @(negedge clk) begin
    quat.ready <= rst ? 1'b0 : ($urandom_range(99) >= idle_pct);
  end

  always @(posedge clk) begin
    quat_t got;
    if (!rst) begin
      if (quat.valid && quat.ready) begin
        got.qw = quat.qw; got.qx = quat.qx; got.qy = quat.qy; got.qz = quat.qz;
        got.br = rmq_pkg::branch_t'(quat.branch_taken);
        got.clamped = quat.clamped;
        sb.check_quat(got);
      end
      if ((mat.valid && mat.ready) || (quat.valid && quat.ready)) watchdog = 0;
      else watchdog++;
      if (watchdog >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // present one matrix word and hold it until taken
  task automatic send_matrix(matrix_t a);
    while ($urandom_range(99) < idle_pct) begin
      mat.valid <= 1'b0;
      @(negedge clk);
    end
    mat.valid <= 1'b1;
    mat.m00 <= a.m[0]; mat.m01 <= a.m[1]; mat.m02 <= a.m[2];
    mat.m10 <= a.m[3]; mat.m11 <= a.m[4]; mat.m12 <= a.m[5];
    mat.m20 <= a.m[6]; mat.m21 <= a.m[7]; mat.m22 <= a.m[8];
    do @(posedge clk); while (!mat.ready);
    sb.note_matrix(a);
    @(negedge clk);
  endtask

  function automatic matrix_t fill_matrix(logic signed [15:0] v);
    matrix_t a;
    foreach (a.m[i]) a.m[i] = v;
    return a;
  endfunction

  function automatic matrix_t random_matrix();
    matrix_t a;
    int k;
    k = $urandom_range(99);
    foreach (a.m[i]) begin
      if (k < 60) a.m[i] = $signed(16'($urandom_range(32768))) - 16'sd16384;
      else if (k < 80) a.m[i] = 16'($urandom());
      else a.m[i] = $signed(16'($urandom_range(64))) - 16'sd32;
    end
    // in about half of the mid-range cases, one strong diagonal entry of random sign
    if (k < 60 && $urandom_range(1)) begin
      a.m[$urandom_range(2) * 4] = $urandom_range(1) ? 16'sd16384 : -16'sd16384;
    end
    return a;
  endfunction

  // directed matrices
  task automatic run_directed();
    matrix_t a;
    int d;
    send_matrix(fill_matrix(16'sd0));
    send_matrix(fill_matrix(16'sh7fff));
    send_matrix(fill_matrix(-16'sh8000));
    send_matrix(fill_matrix(-16'sd1));
    // identity and half-turns about each axis
    for (d = 0; d < 4; d++) begin
      a = fill_matrix(16'sd0);
      a.m[0] = (d == 0 || d == 1) ? 16'sd16384 : -16'sd16384;
      a.m[4] = (d == 0 || d == 2) ? 16'sd16384 : -16'sd16384;
      a.m[8] = (d == 0 || d == 3) ? 16'sd16384 : -16'sd16384;
      send_matrix(a);
    end
    // ties between diagonal entries
    a = fill_matrix(16'sd0); a.m[0] = -16'sd100; a.m[4] = -16'sd100; a.m[8] = -16'sd200;
    send_matrix(a);
    a.m[8] = -16'sd100;
    send_matrix(a);
    // extreme diagonal and off-diagonal entries
    a = fill_matrix(16'sh7fff); a.m[0] = -16'sh8000; a.m[4] = 16'sh7fff; a.m[8] = 16'sh7fff;
    a.m[5] = -16'sh8000; a.m[1] = -16'sh8000;
    send_matrix(a);
    a = fill_matrix(-16'sh8000); a.m[7] = 16'sh7fff; a.m[2] = 16'sh7fff;
    send_matrix(a);
    // trace exactly zero and exactly one lsb
    a = fill_matrix(16'sd5); a.m[0] = 16'sd1; a.m[4] = -16'sd1; a.m[8] = 16'sd0;
    send_matrix(a);
    a.m[8] = 16'sd1;
    send_matrix(a);
  endtask

  initial begin
    int i;
    mat.valid = 1'b0;
    {mat.m00, mat.m01, mat.m02, mat.m10, mat.m11, mat.m12, mat.m20, mat.m21,
     mat.m22} = '0;
    quat.ready = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    run_directed();
    for (i = 0; i < N_RANDOM; i++) begin
      // burst without any idling on either side
      idle_pct = (i >= 600 && i < 900) ? 0 : 10;
      // hold off until the pipeline has drained
      if (i == 1200) begin
        mat.valid <= 1'b0;
        do @(negedge clk); while (sb.pending.size() != 0);
      end
      send_matrix(random_matrix());
    end
    mat.valid <= 1'b0;

    while (sb.pending.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
    if (sb.mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule
